[hdl/assert_macros.svh]
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property, skipped while reset is high.
`define LSH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included.
`define LSH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/lsh_pkg.sv]
// ----------------------------------------------------------------------------
// Lambert shader package
// Request, response and pipeline types and constants of the fragment shader.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 2;
   localparam int NUM_STAGES  = 32;
   localparam int DEPTH_EPS   = 17;
   localparam int AMBIENT     = 3277;

   typedef struct packed {
      logic signed [31:0] u_over_z;
      logic signed [31:0] v_over_z;
      logic signed [31:0] one_over_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic        [7:0]  texel_red;
      logic        [7:0]  texel_green;
      logic        [7:0]  texel_blue;
   } req_type;

   typedef struct packed {
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic               uv_valid;
      logic        [7:0]  shade_red;
      logic        [7:0]  shade_green;
      logic        [7:0]  shade_blue;
   } rsp_type;

   typedef struct packed {
      logic        [47:0] rem_u;
      logic        [47:0] rem_v;
      logic        [31:0] q_u;
      logic        [31:0] q_v;
      logic        [31:0] wabs;
      logic               neg_u;
      logic               neg_v;
      logic               ovf_u;
      logic               ovf_v;
      logic               uv_valid;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [18:0] s;
      logic        [31:0] l2;
      logic        [33:0] ss;
      logic               en;
      logic        [34:0] kk;
      logic        [61:0] rhs;
      logic        [63:0] pp;
      logic        [49:0] qq;
      logic        [14:0] dd;
      logic        [7:0]  red;
      logic        [7:0]  green;
      logic        [7:0]  blue;
   } pipe_type;

endpackage

`default_nettype wire

[hdl/lambert_fragment_shader_unit.sv]
// ----------------------------------------------------------------------------
// Lambert fragment shader unit
// Perspective-correct UV and ambient plus diffuse shading, one fragment a cycle unless stalled.
//
//   channel   ports                              direction
//   request   req_push, req_full, req_data       in
//   response  rsp_empty, rsp_pop, rsp_data       out
//
// Takes one request per cycle while the result queue has room; a response passes
// through the front queue and then the 32-stage restoring divider pipeline,
// whose last stage writes the result queue.
// Reset clears the front queue, the pipeline valid bits and the result queue.
// A full result queue stalls the whole back pipeline; the front queue then
// fills and raises req_full.
// ----------------------------------------------------------------------------
`default_nettype none

module lambert_fragment_shader_unit #(
   parameter int QUEUE_DEPTH = lsh_pkg::QUEUE_DEPTH,
   parameter int OUT_DEPTH   = lsh_pkg::OUT_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   output logic             req_full,
   input  lsh_pkg::req_type req_data,
   output logic             rsp_empty,
   input  wire              rsp_pop,
   output lsh_pkg::rsp_type rsp_data
);

   lsh_pkg::pipe_type head;
   logic              head_valid;
   logic              head_pop;

   lsh_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   lsh_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/lsh_front.sv]
// ----------------------------------------------------------------------------
// Lambert shader front end
// Classifies each request (depth test, magnitudes, overflow) and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_front #(
   parameter int QUEUE_DEPTH = lsh_pkg::QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   output logic             req_full,
   input  lsh_pkg::req_type req_data,
   output lsh_pkg::pipe_type head,
   output logic             head_valid,
   input  wire              head_pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   lsh_pkg::pipe_type mem [QUEUE_DEPTH];
   lsh_pkg::pipe_type entry;
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;
   logic [31:0]   uabs, vabs, wabs;

   always_comb begin
      uabs = req_data.u_over_z[31] ? (~req_data.u_over_z + 32'd1) : req_data.u_over_z;
      vabs = req_data.v_over_z[31] ? (~req_data.v_over_z + 32'd1) : req_data.v_over_z;
      wabs = req_data.one_over_z[31] ? (~req_data.one_over_z + 32'd1)
                                     : req_data.one_over_z;
      entry          = '0;
      entry.rem_u    = {uabs, 16'd0};
      entry.rem_v    = {vabs, 16'd0};
      entry.wabs     = wabs;
      entry.neg_u    = req_data.u_over_z[31] ^ req_data.one_over_z[31];
      entry.neg_v    = req_data.v_over_z[31] ^ req_data.one_over_z[31];
      entry.ovf_u    = {16'd0, uabs} >= {wabs, 16'd0};
      entry.ovf_v    = {16'd0, vabs} >= {wabs, 16'd0};
      entry.uv_valid = wabs > 32'(lsh_pkg::DEPTH_EPS);
      entry.nx       = req_data.normal_x;
      entry.ny       = req_data.normal_y;
      entry.nz       = req_data.normal_z;
      entry.s        = {{3{req_data.normal_x[15]}}, req_data.normal_x}
                     + {{2{req_data.normal_y[15]}}, req_data.normal_y, 1'b0}
                     - {{3{req_data.normal_z[15]}}, req_data.normal_z};
      entry.red      = req_data.texel_red;
      entry.green    = req_data.texel_green;
      entry.blue     = req_data.texel_blue;
   end

   assign req_full   = count_ff == CW'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign push       = req_push && !req_full;
   assign pop        = head_pop && head_valid;
   assign head       = mem[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

[hdl/lsh_back.sv]
// ----------------------------------------------------------------------------
// Lambert shader back end
// Pipelined restoring dividers and Lambert root search, then a result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_back #(
   parameter int OUT_DEPTH = lsh_pkg::OUT_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  lsh_pkg::pipe_type head,
   input  wire               head_valid,
   output logic              head_pop,
   output logic              rsp_empty,
   input  wire               rsp_pop,
   output lsh_pkg::rsp_type  rsp_data
);

   localparam int NS = lsh_pkg::NUM_STAGES;
   localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int CW = $clog2(OUT_DEPTH + 1);

   function automatic lsh_pkg::pipe_type stage_fn(input lsh_pkg::pipe_type p,
                                                  input int i);
      lsh_pkg::pipe_type r;
      logic [63:0]        wsh;
      logic [65:0]        cand;
      logic signed [31:0] sx, sy, sz;
      logic [14:0]        t;
      int                 b;
      r   = p;
      wsh = {32'd0, p.wabs} << (31 - i);
      if ({16'd0, p.rem_u} >= wsh) begin
         r.rem_u = 48'({16'd0, p.rem_u} - wsh);
         r.q_u[31 - i] = 1'b1;
      end
      if ({16'd0, p.rem_v} >= wsh) begin
         r.rem_v = 48'({16'd0, p.rem_v} - wsh);
         r.q_v[31 - i] = 1'b1;
      end
      if (i == 0) begin
         sx   = p.nx * p.nx;
         sy   = p.ny * p.ny;
         sz   = p.nz * p.nz;
         r.l2 = unsigned'(sx) + unsigned'(sy) + unsigned'(sz);
         r.en = !p.s[18] && (p.s != '0);
         r.ss = p.s[16:0] * p.s[16:0];
      end else if (i == 1) begin
         r.kk  = {1'b0, p.l2, 2'b0} + {2'b0, p.l2, 1'b0};
         r.en  = p.en && (p.l2 != '0);
         r.rhs = {p.ss, 28'd0};
         r.pp  = '0;
         r.qq  = '0;
         r.dd  = '0;
      end else if (i <= 16) begin
         b    = 16 - i;
         t    = p.dd | (15'd1 << b);
         cand = {2'b0, p.pp} + ({16'd0, p.qq} << (b + 1)) + ({31'd0, p.kk} << (2 * b));
         if (p.en && (b == 14 || !p.dd[14]) && cand <= {4'd0, p.rhs}) begin
            r.dd = t;
            r.pp = 64'(cand);
            r.qq = p.qq + 50'({15'd0, p.kk} << b);
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_fn(input logic [31:0] q, input logic ovf,
                                          input logic neg, input logic ok);
      logic [31:0] r;
      if (!ok) begin
         r = '0;
      end else if (neg) begin
         r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
      end else begin
         r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
      end
      return r;
   endfunction

   function automatic logic [7:0] shade_fn(input logic [7:0] tx, input logic [14:0] f);
      logic [23:0] prod;
      prod = 24'(tx) * 24'(f) + 24'd8192;
      return (prod[23:14] > 10'd255) ? 8'd255 : prod[21:14];
   endfunction

   lsh_pkg::pipe_type st_ff [NS];
   lsh_pkg::pipe_type st_in [NS];
   logic [NS-1:0]     vld_ff;
   logic              adv;
   lsh_pkg::rsp_type  out_word;
   lsh_pkg::pipe_type last;
   logic [14:0]       factor;

   lsh_pkg::rsp_type  omem [OUT_DEPTH];
   logic [PW-1:0]     owp_ff, owp_in, orp_ff, orp_in;
   logic [CW-1:0]     ocnt_ff, ocnt_in;
   logic              opush, opop;

   assign adv      = ocnt_ff != CW'(OUT_DEPTH);
   assign head_pop = head_valid && adv;

   always_comb begin
      st_in[0] = stage_fn(head, 0);
      for (int i = 1; i < NS; i++) begin
         st_in[i] = stage_fn(st_ff[i-1], i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], head_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NS; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   always_comb begin
      last                 = st_ff[NS-1];
      factor               = 15'(lsh_pkg::AMBIENT) + last.dd;
      out_word.tex_u       = sat_fn(last.q_u, last.ovf_u, last.neg_u, last.uv_valid);
      out_word.tex_v       = sat_fn(last.q_v, last.ovf_v, last.neg_v, last.uv_valid);
      out_word.uv_valid    = last.uv_valid;
      out_word.shade_red   = shade_fn(last.red, factor);
      out_word.shade_green = shade_fn(last.green, factor);
      out_word.shade_blue  = shade_fn(last.blue, factor);
   end

   assign opush     = adv && vld_ff[NS-1];
   assign rsp_empty = ocnt_ff == '0;
   assign opop      = rsp_pop && !rsp_empty;
   assign rsp_data  = omem[orp_ff];

   always_comb begin
      owp_in  = owp_ff;
      orp_in  = orp_ff;
      ocnt_in = ocnt_ff;
      if (opush) begin
         owp_in = (owp_ff == PW'(OUT_DEPTH - 1)) ? '0 : owp_ff + PW'(1);
      end
      if (opop) begin
         orp_in = (orp_ff == PW'(OUT_DEPTH - 1)) ? '0 : orp_ff + PW'(1);
      end
      if (opush && !opop) begin
         ocnt_in = ocnt_ff + CW'(1);
      end else if (opop && !opush) begin
         ocnt_in = ocnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owp_ff  <= owp_in;
         orp_ff  <= orp_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         omem[owp_ff] <= out_word;
      end
   end

endmodule

`default_nettype wire

[hdl/lsh_checker.sv]
// ----------------------------------------------------------------------------
// Lambert shader checker
// Port-level checks of the fragment shader unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsh_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_full,
   input wire              rsp_empty,
   input wire              rsp_pop,
   input lsh_pkg::rsp_type rsp_data
);

   `LSH_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty && !req_full, "not empty after reset")
   `LSH_ASSERT(a_invalid_zero, clock, reset, !rsp_empty && !rsp_data.uv_valid |-> rsp_data.tex_u == 0 && rsp_data.tex_v == 0, "uv not zero when invalid")
   `LSH_ASSERT(a_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data), "stalled response changed")

endmodule

bind lambert_fragment_shader_unit lsh_checker u_lsh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[tb/sv/tb_lambert_fragment_shader_unit.sv]
// ----------------------------------------------------------------------------
// Lambert fragment shader unit testbench
// Drives fragment requests through the push/full queue port and pops responses
// with random gaps on both sides. A local predictor computes the expected UV
// and shaded colour of each request, and every response is compared field by
// field against the oldest expected response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_lambert_fragment_shader_unit;

   localparam int DRAIN_CYCLES = 80;

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   lsh_pkg::req_type req_data;
   logic             rsp_empty;
   logic             rsp_pop;
   lsh_pkg::rsp_type rsp_data;

   lsh_pkg::req_type pending_reqs[$];
   lsh_pkg::rsp_type expected_rsps[$];
   int      error_count;
   int      rsp_count;
   int      tiny_depth_count;
   int      saturate_count;
   bit      hold_push;
   bit      quiet_phase;

   lambert_fragment_shader_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] divide_uv(longint num, longint w);
      longint q;
      q = (num * 65536) / w;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function automatic logic [7:0] shade_channel(logic [7:0] texel, longint factor);
      longint r;
      r = (longint'(texel) * factor + 8192) >>> 14;
      return (r > 255) ? 8'd255 : r[7:0];
   endfunction

   function automatic lsh_pkg::rsp_type shade_fragment(lsh_pkg::req_type rq);
      lsh_pkg::rsp_type rs;
      longint   w, wabs, nx, ny, nz, s, l2, d, t;
      bit [127:0] lhs, rhs;
      w    = rq.one_over_z;
      wabs = (w < 0) ? -w : w;
      if (wabs > lsh_pkg::DEPTH_EPS) begin
         rs.tex_u    = divide_uv(longint'(rq.u_over_z), w);
         rs.tex_v    = divide_uv(longint'(rq.v_over_z), w);
         rs.uv_valid = 1'b1;
      end else begin
         rs.tex_u    = '0;
         rs.tex_v    = '0;
         rs.uv_valid = 1'b0;
      end
      nx = rq.normal_x;
      ny = rq.normal_y;
      nz = rq.normal_z;
      s  = nx + 2 * ny - nz;
      l2 = nx * nx + ny * ny + nz * nz;
      d  = 0;
      if (l2 != 0 && s > 0) begin
         rhs = 128'(s * s) << 28;
         for (int b = 14; b >= 0; b--) begin
            t   = d | (64'sd1 << b);
            lhs = 128'(t * t) * 128'(6 * l2);
            if (t <= 16384 && lhs <= rhs) d = t;
         end
      end
      rs.shade_red   = shade_channel(rq.texel_red, lsh_pkg::AMBIENT + d);
      rs.shade_green = shade_channel(rq.texel_green, lsh_pkg::AMBIENT + d);
      rs.shade_blue  = shade_channel(rq.texel_blue, lsh_pkg::AMBIENT + d);
      return rs;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on response %0d: %s got %0d want %0d",
               rsp_count, field, got, want);
      error_count++;
   endtask

   function automatic lsh_pkg::req_type random_fragment();
      lsh_pkg::req_type rq;
      rq = {$urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom)};
      case ($urandom_range(0, 9))
         0: rq.one_over_z = 32'($signed($urandom_range(0, 40)) - 20);
         1: rq.one_over_z = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         2: begin
            rq.one_over_z = $urandom_range(1 << 22, 1 << 26);
            rq.u_over_z   = $signed($urandom) >>> $urandom_range(0, 12);
            rq.v_over_z   = $signed($urandom) >>> $urandom_range(0, 12);
         end
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: begin
            rq.normal_x = $signed(16'($urandom)) >>> 2;
            rq.normal_y = $signed(16'($urandom)) >>> 2;
            rq.normal_z = $signed(16'($urandom)) >>> 2;
         end
         1: begin
            rq.normal_x = 16'($urandom_range(0, 8)) - 16'd4;
            rq.normal_y = 16'($urandom_range(0, 8)) - 16'd4;
            rq.normal_z = 16'($urandom_range(0, 8)) - 16'd4;
         end
         default: ;
      endcase
      return rq;
   endfunction

   function automatic lsh_pkg::req_type make_fragment(int uz, int vz, int w, shortint nx,
                                                      shortint ny, shortint nz,
                                                      byte unsigned r, byte unsigned g,
                                                      byte unsigned b);
      lsh_pkg::req_type rq;
      rq.u_over_z = uz; rq.v_over_z = vz; rq.one_over_z = w;
      rq.normal_x = nx; rq.normal_y = ny; rq.normal_z = nz;
      rq.texel_red = r; rq.texel_green = g; rq.texel_blue = b;
      return rq;
   endfunction

   // request capture
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         expected_rsps.push_back(shade_fragment(pending_reqs.pop_front()));
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (!hold_push && pending_reqs.size() != 0 &&
             (quiet_phase || $urandom_range(0, 99) >= 17)) begin
            req_data <= pending_reqs[0];
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      lsh_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected response %0d", rsp_count);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.tex_u !== want.tex_u)
               report_mismatch("tex_u", rsp_data.tex_u, want.tex_u);
            if (rsp_data.tex_v !== want.tex_v)
               report_mismatch("tex_v", rsp_data.tex_v, want.tex_v);
            if (rsp_data.uv_valid !== want.uv_valid)
               report_mismatch("uv_valid", rsp_data.uv_valid, want.uv_valid);
            if (rsp_data.shade_red !== want.shade_red)
               report_mismatch("shade_red", rsp_data.shade_red, want.shade_red);
            if (rsp_data.shade_green !== want.shade_green)
               report_mismatch("shade_green", rsp_data.shade_green, want.shade_green);
            if (rsp_data.shade_blue !== want.shade_blue)
               report_mismatch("shade_blue", rsp_data.shade_blue, want.shade_blue);
            if (!want.uv_valid) tiny_depth_count++;
            if (want.uv_valid && (want.tex_u == 32'h7fffffff || want.tex_u == 32'h80000000))
               saturate_count++;
         end
         rsp_count++;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= quiet_phase || $urandom_range(0, 99) >= 17;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int      drain;
      reset = 1'b1;
      req_push = 1'b0;
      rsp_pop = 1'b0;
      req_data = '0;
      hold_push = 1'b1;
      quiet_phase = 1'b0;
      error_count = 0;
      rsp_count = 0;
      tiny_depth_count = 0;
      saturate_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: depth edges, normal extremes, zero normal, texel extremes
      pending_reqs.push_back(make_fragment(1 << 24, 1 << 24, 1 << 24, 0, 0, 0, 255, 255, 255));
      pending_reqs.push_back(make_fragment(5, -5, 17, 16384, 0, 0, 1, 2, 3));
      pending_reqs.push_back(make_fragment(5, -5, -17, 0, 16384, 0, 255, 0, 128));
      pending_reqs.push_back(make_fragment(5, -5, 18, 0, 0, -16384, 200, 100, 50));
      pending_reqs.push_back(make_fragment(7, 7, -18, 1, 2, -1, 255, 255, 255));
      pending_reqs.push_back(make_fragment(3, 3, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_fragment(32'h7fffffff, 32'h80000000, 1000, 32767, 32767,
                                           -32768, 255, 255, 255));
      pending_reqs.push_back(make_fragment(32'h80000000, 32'h7fffffff, -1000, -32768,
                                           -32768, 32767, 255, 0, 255));
      pending_reqs.push_back(make_fragment(32'h80000000, 32'h80000000, 32'h80000000,
                                           -32768, 0, 0, 17, 34, 51));
      pending_reqs.push_back(make_fragment(32'h7fffffff, -1, 32'h7fffffff, 0, -32768, 0,
                                           0, 255, 0));
      pending_reqs.push_back(make_fragment(-1, 1, -1, 0, 0, 32767, 128, 129, 127));
      pending_reqs.push_back(make_fragment(1 << 30, -(1 << 30), 1 << 10, 100, 200, -100,
                                           255, 254, 1));
      pending_reqs.push_back(make_fragment(0, 0, 32'h80000001, -1, -1, -1, 255, 255, 255));
      hold_push = 1'b0;
      for (int i = 0; i < 1600; i++) begin
         pending_reqs.push_back(random_fragment());
         if (i == 300) begin
            wait (pending_reqs.size() == 0);
            hold_push = 1'b1;
            wait (expected_rsps.size() == 0);
            @(negedge clock);
            hold_push = 1'b0;
            quiet_phase = 1'b1;
         end
         if (i == 700) begin
            wait (pending_reqs.size() == 0);
            quiet_phase = 1'b0;
         end
      end
      wait (pending_reqs.size() == 0);
      repeat (2) @(negedge clock);
      wait (expected_rsps.size() == 0);
      drain = 0;
      while (drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end
      $display("%0d responses checked, %0d with tiny depth, %0d with saturated u",
               rsp_count, tiny_depth_count, saturate_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
